>>> hdl/i2cem_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the I2C EEPROM master sequencer.
package i2cem_pkg;

  localparam logic [2:0] KIND_BEGIN_WRITE   = 3'd0;
  localparam logic [2:0] KIND_BEGIN_READ    = 3'd1;
  localparam logic [2:0] KIND_START_SENT    = 3'd2;
  localparam logic [2:0] KIND_BYTE_SENT     = 3'd3;
  localparam logic [2:0] KIND_BYTE_RECEIVED = 3'd4;
  localparam logic [2:0] KIND_BAD_STATUS    = 3'd5;
  localparam logic [2:0] KIND_TIMEOUT       = 3'd6;

  localparam logic [7:0] ADDR_RW_MASK = 8'hFE;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] dev_addr;
    logic [7:0] mem_offset;
    logic [7:0] length;
    logic       acked;
    logic [7:0] rx_byte;
    logic [7:0] tx_byte;
  } in_item_t;

  typedef struct packed {
    logic       load_data;
    logic [7:0] bus_data;
    logic       set_start;
    logic       set_stop;
    logic       send_ack;
    logic       store_rx;
    logic [7:0] data_index;
    logic       consumed_tx;
    logic       bus_reset;
    logic       busy_res;
    logic       rejected;
  } out_item_t;

  typedef struct packed {
    logic       busy;
    logic       read_mode;
    logic       offset_pending;
    logic       random_read;
    logic       restart_pending;
    logic [7:0] byte_count;
    logic [7:0] slave_addr;
    logic [7:0] mem_addr;
    logic [7:0] xfer_len;
  } seq_ctx_t;

endpackage

>>> hdl/i2cem_step.sv
`timescale 1ns / 1ps
// Per-event decision logic: next sequencer context and the result item.
module i2cem_step import i2cem_pkg::*; (
  input  seq_ctx_t  ctx_i,
  input  in_item_t  item_i,
  input  logic      ack_poll_i,
  output seq_ctx_t  ctx_o,
  output out_item_t res_o
);

  logic [7:0] cnt_after;

  always_comb begin
    ctx_o     = ctx_i;
    res_o     = '0;
    cnt_after = ctx_i.byte_count;
    unique case (item_i.kind)
      KIND_BEGIN_WRITE, KIND_BEGIN_READ: begin
        if (ctx_i.busy) begin
          res_o.rejected = 1'b1;
        end else begin
          ctx_o.busy            = 1'b1;
          ctx_o.slave_addr      = item_i.dev_addr;
          ctx_o.read_mode       = 1'b0;
          ctx_o.offset_pending  = 1'b1;
          ctx_o.random_read     = (item_i.kind == KIND_BEGIN_READ);
          ctx_o.restart_pending = 1'b0;
          ctx_o.mem_addr        = item_i.mem_offset;
          ctx_o.xfer_len        = item_i.length;
          ctx_o.byte_count      = '0;
          res_o.set_start       = 1'b1;
        end
      end
      KIND_START_SENT: begin
        res_o.load_data  = 1'b1;
        res_o.bus_data   = (ctx_i.slave_addr & ADDR_RW_MASK) | {7'd0, ctx_i.read_mode};
        ctx_o.byte_count = '0;
      end
      KIND_BYTE_SENT: begin
        priority if (!item_i.acked) begin
          if (ack_poll_i) begin
            res_o.set_start = 1'b1;
          end else begin
            res_o.bus_reset = 1'b1;
            ctx_o.busy      = 1'b0;
          end
        end else if (ctx_i.restart_pending) begin
          res_o.set_start       = 1'b1;
          ctx_o.restart_pending = 1'b0;
        end else if (ctx_i.offset_pending) begin
          ctx_o.offset_pending = 1'b0;
          res_o.load_data      = 1'b1;
          res_o.bus_data       = ctx_i.mem_addr;
          if (ctx_i.random_read) begin
            ctx_o.restart_pending = 1'b1;
            ctx_o.read_mode       = 1'b1;
          end
        end else if (!ctx_i.read_mode) begin
          if (ctx_i.byte_count < ctx_i.xfer_len) begin
            res_o.load_data   = 1'b1;
            res_o.bus_data    = item_i.tx_byte;
            res_o.consumed_tx = 1'b1;
            res_o.data_index  = ctx_i.byte_count;
            ctx_o.byte_count  = ctx_i.byte_count + 8'd1;
          end else begin
            res_o.set_stop = 1'b1;
            ctx_o.busy     = 1'b0;
          end
        end else begin
          // Read address acked: the data bytes arrive as receive events.
        end
      end
      KIND_BYTE_RECEIVED: begin
        if (ctx_i.byte_count < ctx_i.xfer_len) begin
          res_o.store_rx   = 1'b1;
          res_o.data_index = ctx_i.byte_count;
          res_o.send_ack   = 1'b1;
          cnt_after        = ctx_i.byte_count + 8'd1;
        end
        ctx_o.byte_count = cnt_after;
        // The last byte is nacked and the transfer closes with a stop.
        if (cnt_after == ctx_i.xfer_len) begin
          ctx_o.busy     = 1'b0;
          res_o.send_ack = 1'b0;
          res_o.set_stop = 1'b1;
        end
      end
      KIND_TIMEOUT: begin
        res_o.bus_reset = 1'b1;
        ctx_o.busy      = 1'b0;
      end
      default: begin
        // Bad status and the unused code both fail the transfer.
        res_o.bus_reset = 1'b1;
        ctx_o.busy      = 1'b0;
      end
    endcase
    res_o.busy_res = ctx_o.busy;
  end

endmodule

>>> hdl/i2c_eeprom_master_sequencer_top.sv
`timescale 1ns / 1ps
// An event is held in the input register; the context updates as it enters the result register.
// Throughput: one event per cycle while the output is not stalled.
// The input stage stalls only while the result register is full and stalled.
// Synchronous active-low reset clears the context and valid flags; ack polling resets enabled.
// Top level of the I2C EEPROM master sequencer.
module i2c_eeprom_master_sequencer_top import i2cem_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data
);

  logic      in_valid_r;
  in_item_t  in_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  seq_ctx_t  ctx_r;
  seq_ctx_t  ctx_nxt;
  out_item_t res_nxt;
  logic      ack_poll_r;
  logic      out_free;
  logic      advance;
  logic      in_take;

  assign out_free = !out_valid_r || !out_stall;
  assign advance  = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  i2cem_step u_step (
    .ctx_i      (ctx_r),
    .item_i     (in_item_r),
    .ack_poll_i (ack_poll_r),
    .ctx_o      (ctx_nxt),
    .res_o      (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      ctx_r       <= '0;
      ack_poll_r  <= 1'b1;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (out_free) begin
        out_valid_r <= in_valid_r;
      end
      if (advance) begin
        ctx_r <= ctx_nxt;
      end
      if (cfg_wr_en) begin
        ack_poll_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_item;
    end
    if (advance) begin
      out_item_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_busy_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> ctx_r.busy == out_item_r.busy_res)
    else $error("context busy flag differs from delivered busy_res");

  a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.rejected |-> out_item_r.busy_res && !out_item_r.set_start)
    else $error("rejected begin changed the transfer");

  a_reset_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.bus_reset |-> !out_item_r.busy_res && !out_item_r.set_stop)
    else $error("bus reset left the sequencer busy");

  a_one_handoff: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_item_r.store_rx && out_item_r.consumed_tx))
    else $error("store and consume in the same result");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r && out_stall)
    else $error("input stalled with room in the result register");

endmodule
